// ===== hdl/sst_pkg.sv =====
// Shared types, codes and defaults for the sorted station table.
`default_nettype none
package sst_pkg;

  // Default table depth.
  localparam int DEF_MAX_POINTS = 64;

  // Operation codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Control states of the top level.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_UPD  = 1'b1
  } state_t;

  // One stored point.
  typedef struct packed {
    logic [31:0]        st;
    logic signed [31:0] el;
    logic signed [15:0] rot;
  } point_t;

  // Broadcast to every cell when an operation is taken in.
  typedef struct packed {
    logic        capture;
    logic        excl;
    logic [5:0]  idx;
    logic [31:0] key;
  } cmp_ctl_t;

  // Broadcast to every cell when the table is rewritten.
  typedef struct packed {
    logic   apply;
    point_t new_pt;
  } upd_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/sst_ifs.sv =====
// Handshake interfaces for the operation and result channels.
`default_nettype none
interface sst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         point_index;
  logic [31:0]        key_station;
  logic signed [31:0] new_elevation;
  logic signed [15:0] new_rotation;

  modport source (output valid, kind, point_index, key_station, new_elevation,
                  new_rotation, input ready);
  modport sink (input valid, kind, point_index, key_station, new_elevation,
                new_rotation, output ready);
endinterface

interface sst_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] result_index;
  logic [6:0] point_count;

  modport source (output valid, status, result_index, point_count, input ready);
  modport sink (input valid, status, result_index, point_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/sst_cell.sv =====
// One table slot: holds a point, compares it with the key and shifts with its neighbors.
`default_nettype none
module sst_cell import sst_pkg::*; #(
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic [IW-1:0] cell_idx,
  input  wire logic [CW-1:0] count,
  input  wire cmp_ctl_t      cmp,
  input  wire upd_ctl_t      upd,
  input  wire logic [CW-1:0] new_pos,
  input  wire logic [CW-1:0] del_pos,
  input  wire point_t        left_pt,
  input  wire point_t        right_pt,
  output point_t             pt,
  output logic               lt,
  output logic               eqx,
  output logic               hit
);

  point_t pt_r, pt_nxt;
  logic   lt_r, lt_nxt;
  logic   eqx_r, eqx_nxt;
  logic   hit_r, hit_nxt;
  logic   valid;
  logic   eq;
  logic   self;
  logic [CW-1:0] j;

  assign j = CW'(cell_idx);

  // Compare the stored station with the incoming key.
  always_comb begin
    valid   = j < count;
    self    = 32'(cell_idx) == 32'(cmp.idx);
    eq      = valid && (pt_r.st == cmp.key);
    lt_nxt  = valid && (pt_r.st < cmp.key);
    eqx_nxt = eq && !(cmp.excl && self);
    hit_nxt = lt_nxt && self;
  end

  // Choose the slot's next contents: keep, take a neighbor, or take the new point.
  always_comb begin
    pt_nxt = pt_r;
    if (upd.apply) begin
      if (new_pos <= del_pos) begin
        if (j == new_pos) begin
          pt_nxt = upd.new_pt;
        end else if (j > new_pos && j <= del_pos) begin
          pt_nxt = left_pt;
        end
      end else begin
        if (j == new_pos) begin
          pt_nxt = upd.new_pt;
        end else if (j >= del_pos && j < new_pos) begin
          pt_nxt = right_pt;
        end
      end
    end
  end

  // Point storage and compare flags.
  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
    if (cmp.capture) begin
      lt_r  <= lt_nxt;
      eqx_r <= eqx_nxt;
      hit_r <= hit_nxt;
    end
  end

  assign pt  = pt_r;
  assign lt  = lt_r;
  assign eqx = eqx_r;
  assign hit = hit_r;

endmodule
`default_nettype wire

// ===== hdl/sst_chain.sv =====
// Row of table cells with the encoder that turns their flags into a position.
`default_nettype none
module sst_chain import sst_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int IW = $clog2(MAX_POINTS),
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic          clk,
  input  wire logic [CW-1:0] count,
  input  wire cmp_ctl_t      cmp,
  input  wire upd_ctl_t      upd,
  input  wire logic [CW-1:0] new_pos,
  input  wire logic [CW-1:0] del_pos,
  output logic [CW-1:0]      below_cnt,
  output logic               any_eq,
  output logic               first_eq,
  output logic               idx_below
);

  point_t pts [MAX_POINTS];
  logic [MAX_POINTS-1:0] lt_v;
  logic [MAX_POINTS-1:0] eq_v;
  logic [MAX_POINTS-1:0] hit_v;
  logic [MAX_POINTS+1:0] ltx;

  // Cells, each linked to its two neighbors; the ends see their own point.
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    point_t lp, rp;
    assign lp = (g == 0) ? pts[g] : pts[(g == 0) ? 0 : g - 1];
    assign rp = (g == MAX_POINTS - 1) ? pts[g] : pts[(g == MAX_POINTS - 1) ? g : g + 1];

    sst_cell #(.IW(IW), .CW(CW)) u_cell (
      .clk      (clk),
      .cell_idx (IW'(g)),
      .count    (count),
      .cmp      (cmp),
      .upd      (upd),
      .new_pos  (new_pos),
      .del_pos  (del_pos),
      .left_pt  (lp),
      .right_pt (rp),
      .pt       (pts[g]),
      .lt       (lt_v[g]),
      .eqx      (eq_v[g]),
      .hit      (hit_v[g])
    );
  end

  // The less-than flags form a thermometer; encode where it ends.
  assign ltx = {1'b0, lt_v, 1'b1};

  always_comb begin
    below_cnt = '0;
    for (int i = 0; i <= MAX_POINTS; i++) begin
      if (ltx[i] && !ltx[i+1]) begin
        below_cnt = below_cnt | CW'(i);
      end
    end
  end

  assign any_eq    = |eq_v;
  assign first_eq  = eq_v[0];
  assign idx_below = |hit_v;

endmodule
`default_nettype wire

// ===== hdl/sorted_station_table.sv =====
// Top level of the sorted station table: control, point count and result register.
//
//   channel   | direction | contents
//   in_chan   | sink      | kind, point_index, key_station, new_elevation, new_rotation
//   out_chan  | source    | status, result_index, point_count
//
// Per operation, the transfer edge latches the compare flags in every cell, and the
// commit edge in the update state rewrites the cell row and loads the result register.
// Operations are taken only in the idle state, also while the result register drains.
// A result that is not taken holds the block in its update state until out_chan.ready.
// Reset (synchronous, active low) empties the table; stored points are not cleared.
`default_nettype none
module sorted_station_table import sst_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sst_in_if.sink    in_chan,
  sst_out_if.source out_chan
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;
  logic   accept;
  logic   commit;

  // Held operation.
  kind_t              kind_r;
  logic [5:0]         idx_r;
  point_t             pt_r;
  logic [CW-1:0]      count_r, count_nxt;

  // Result register.
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;

  cmp_ctl_t           cmp;
  upd_ctl_t           upd;
  logic [CW-1:0]      new_pos, del_pos;
  logic [CW-1:0]      below_cnt;
  logic               any_eq, first_eq, idx_below;
  logic               idx_ok;
  logic               apply;

  assign accept = in_chan.valid && in_chan.ready;

  // Broadcast to the cells at the operation's transfer.
  assign cmp.capture = accept;
  assign cmp.excl    = kind_t'(in_chan.kind) == KIND_MODIFY;
  assign cmp.idx     = in_chan.point_index;
  assign cmp.key     = in_chan.key_station;

  sst_chain #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_chain (
    .clk       (clk),
    .count     (count_r),
    .cmp       (cmp),
    .upd       (upd),
    .new_pos   (new_pos),
    .del_pos   (del_pos),
    .below_cnt (below_cnt),
    .any_eq    (any_eq),
    .first_eq  (first_eq),
    .idx_below (idx_below)
  );

  // Decide the outcome of the held operation and the shift pattern.
  always_comb begin
    idx_ok     = 32'(idx_r) < 32'(count_r);
    apply      = 1'b0;
    new_pos    = CW'(MAX_POINTS);
    del_pos    = CW'(MAX_POINTS);
    count_nxt  = count_r;
    status_nxt = ST_OK;
    pos_nxt    = '0;
    case (kind_r)
      KIND_INSERT: begin
        if (count_r == CW'(MAX_POINTS)) begin
          status_nxt = ST_FULL;
        end else if (any_eq) begin
          status_nxt = ST_DUPLICATE;
        end else begin
          apply     = 1'b1;
          new_pos   = below_cnt;
          pos_nxt   = below_cnt;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_DELETE: begin
        if (!idx_ok) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          apply     = 1'b1;
          del_pos   = CW'(idx_r);
          count_nxt = count_r - CW'(1);
        end
      end
      KIND_MODIFY: begin
        if (!idx_ok) begin
          status_nxt = ST_BAD_INDEX;
        end else if (any_eq) begin
          status_nxt = ST_DUPLICATE;
        end else begin
          apply   = 1'b1;
          del_pos = CW'(idx_r);
          new_pos = below_cnt - CW'(idx_below);
          pos_nxt = below_cnt - CW'(idx_below);
        end
      end
      default: begin
        if ((below_cnt == '0 && !first_eq) || below_cnt == count_r) begin
          status_nxt = ST_RANGE;
        end else if (below_cnt != '0) begin
          pos_nxt = below_cnt - CW'(1);
        end
      end
    endcase
  end

  assign upd.apply  = apply && commit;
  assign upd.new_pt = pt_r;

  // Next state and handshake.
  always_comb begin
    state_nxt     = state_r;
    commit        = 1'b0;
    in_chan.ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        commit = !out_valid_r || out_chan.ready;
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operation and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= kind_t'(in_chan.kind);
      idx_r      <= in_chan.point_index;
      pt_r.st    <= in_chan.key_station;
      pt_r.el    <= in_chan.new_elevation;
      pt_r.rot   <= in_chan.new_rotation;
    end
    if (commit) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.result_index = 6'(pos_r);
  assign out_chan.point_count  = 7'(count_r);

endmodule
`default_nettype wire
